[design/sfs_pkg.sv]
// shared types and constants for the sensor frame sync and checksum block
package sfs_pkg;

    // header bytes that open a frame
    localparam logic [7:0] HDR_TDS   = 8'hAA;
    localparam logic [7:0] HDR_TEMP  = 8'hAB;
    localparam logic [7:0] HDR_OTHER = 8'hAC;

    // result queue depth and the width of its fill level
    localparam int RESULT_DEPTH = 3;
    localparam int LEVEL_W      = 2;

    // input word: one received byte
    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_word_t;

    // output word: one decoded frame
    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [15:0] first_value;
        logic [15:0] second_value;
    } frame_word_t;

endpackage

[design/sfs_stream_if.sv]
// valid/ready stream channel carrying one word per handshake
interface sfs_stream_if #(
    parameter type data_t = logic
) ();
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/sfs_frame_check.sv]
// input register, byte window, running checksum and frame check
module sfs_frame_check #(
    parameter int FRAME_LENGTH = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    output logic                 pending,
    output logic                 res_valid,
    output sfs_pkg::frame_word_t res
);
    localparam int WIN_DEPTH = FRAME_LENGTH - 1;
    localparam int FILL_W    = $clog2(FRAME_LENGTH);

    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic [7:0]       window_reg [WIN_DEPTH];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]       sum_reg, sum_next;

    logic             full;
    logic             hdr_ok;
    logic             match;
    logic [7:0]       kind_diff;
    logic [7:0]       frame_byte [1:4];

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    // window shifts on every valid byte; only the newest fill_reg entries are meaningful
    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            for (int k = 0; k < WIN_DEPTH - 1; k++)
            begin
                window_reg[k] <= window_reg[k + 1];
            end
            window_reg[WIN_DEPTH - 1] <= byte_reg;
        end
    end

    assign full = (fill_reg == FILL_W'(WIN_DEPTH));

    always_comb
    begin
        unique case (window_reg[0]) inside
            sfs_pkg::HDR_TDS, sfs_pkg::HDR_TEMP, sfs_pkg::HDR_OTHER: hdr_ok = 1'b1;
            default:                                                 hdr_ok = 1'b0;
        endcase
    end

    // sum_reg holds the byte sum of the valid window entries
    assign match = valid_reg && full && hdr_ok && (sum_reg == byte_reg);

    always_comb
    begin
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (valid_reg)
        begin
            if (match)
            begin
                fill_next = '0;
                sum_next  = '0;
            end
            else if (full)
            begin
                sum_next = sum_reg + byte_reg - window_reg[0];
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
                sum_next  = sum_reg + byte_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    // frame bytes one to four; offsets past the frame read as zero
    for (genvar k = 1; k <= 4; k++)
    begin : g_frame_byte
        if (k < WIN_DEPTH)
        begin : g_win
            assign frame_byte[k] = window_reg[k];
        end
        else if (k == WIN_DEPTH)
        begin : g_new
            assign frame_byte[k] = byte_reg;
        end
        else
        begin : g_none
            assign frame_byte[k] = 8'h00;
        end
    end

    assign kind_diff = window_reg[0] - sfs_pkg::HDR_TDS;

    assign pending          = valid_reg;
    assign res_valid        = match;
    assign res.frame_kind   = kind_diff[1:0];
    assign res.first_value  = {frame_byte[1], frame_byte[2]};
    assign res.second_value = {frame_byte[3], frame_byte[4]};

endmodule

[design/sfs_result_fifo.sv]
// small result queue that drives the output channel
module sfs_result_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  sfs_pkg::frame_word_t           push_data,
    output logic [sfs_pkg::LEVEL_W-1:0]    level,
    sfs_stream_if.source                   frame
);
    localparam logic [sfs_pkg::LEVEL_W-1:0] LAST = sfs_pkg::LEVEL_W'(sfs_pkg::RESULT_DEPTH - 1);

    sfs_pkg::frame_word_t          mem [sfs_pkg::RESULT_DEPTH];
    logic [sfs_pkg::LEVEL_W-1:0]   wr_ptr_reg, rd_ptr_reg, count_reg;
    logic [sfs_pkg::LEVEL_W-1:0]   wr_ptr_next, rd_ptr_next, count_next;
    logic                          pop;

    assign pop = frame.valid && frame.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + sfs_pkg::LEVEL_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + sfs_pkg::LEVEL_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + sfs_pkg::LEVEL_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - sfs_pkg::LEVEL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign frame.valid = (count_reg != '0);
    assign frame.data  = mem[rd_ptr_reg];
    assign level       = count_reg;

endmodule

[design/sensor_frame_sync_checksum.sv]
// top level of the sensor frame sync and checksum block
//
// takes one received serial byte per word on rx and looks for sensor frames of
// FRAME_LENGTH bytes: a header of 0xAA, 0xAB or 0xAC, payload bytes, and a last
// byte equal to the mod-256 sum of all bytes before it. the check runs on the
// newest FRAME_LENGTH bytes seen since the last good frame, so after a good
// frame the next one must be built from fresh bytes. each good frame gives one
// word on frame: the kind (0 for 0xAA, 1 for 0xAB, 2 for 0xAC) and two
// big-endian 16-bit values from bytes one-two and three-four; temperatures
// come out as raw hundredths. bytes past the end of a short frame read as zero.
// a byte is taken every cycle while rx is ready; a result passes through the
// input register and then the result queue. the result queue holds three
// words, so rx stays ready while the output side is stalled until the queue
// could overflow.
module sensor_frame_sync_checksum #(
    parameter int FRAME_LENGTH = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    sfs_stream_if.sink   rx,
    sfs_stream_if.source frame
);
    // check stage outputs
    logic                        pending;
    logic                        res_valid;
    sfs_pkg::frame_word_t        res;
    logic [sfs_pkg::LEVEL_W-1:0] level;
    logic                        rx_accept;

    // room for the queued words plus the one byte still in the check stage
    assign rx.ready  = ({1'b0, level} + {2'b00, pending}) < 3'(sfs_pkg::RESULT_DEPTH);
    assign rx_accept = rx.valid && rx.ready;

    // window, running checksum and header decode
    sfs_frame_check #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (rx_accept),
        .rx_byte   (rx.data.rx_byte),
        .pending   (pending),
        .res_valid (res_valid),
        .res       (res)
    );

    // result queue toward the output channel
    sfs_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .level     (level),
        .frame     (frame)
    );

endmodule
